@@ design/obm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obm_pkg
// Shared types and constants for the order book matcher.
// ----------------------------------------------------------------------------
package obm_pkg;

	localparam int SIDE_DEPTH_DEF = 32;

	localparam logic FUNC_ADD   = 1'b0;
	localparam logic FUNC_MATCH = 1'b1;
	localparam logic SIDE_SELL  = 1'b0;
	localparam logic SIDE_BUY   = 1'b1;

	localparam logic [1:0] KIND_TRADE  = 2'd0;
	localparam logic [1:0] KIND_DONE   = 2'd1;
	localparam logic [1:0] KIND_ADDED  = 2'd2;
	localparam logic [1:0] KIND_FULL   = 2'd3;

	typedef struct packed {
		logic [31:0] price;
		logic [31:0] qty;
		logic [31:0] otime;
		logic [31:0] ident;
		logic [15:0] instr;
	} entry_t;

endpackage

@@ design/obm_book_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obm_book_ram
// Book entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module obm_book_ram #(
	parameter int SIDE_DEPTH = obm_pkg::SIDE_DEPTH_DEF,
	localparam int AW = $clog2(2 * SIDE_DEPTH)
) (
	input  logic           clk,
	input  logic           we,
	input  logic [AW-1:0]  wr_addr,
	input  obm_pkg::entry_t wr_data,
	input  logic           rd_en,
	input  logic [AW-1:0]  rd_addr,
	output obm_pkg::entry_t rd_data
);

	obm_pkg::entry_t mem [2 * SIDE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ design/order_book_matcher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_book_matcher
// Two-sided limit order book with price-time priority matching.
// ----------------------------------------------------------------------------
// Add: walks its side from the tail, shifting back each entry it ranks ahead of, then
//   writes the order into the freed slot; an add to a full side is refused with a full status.
// Match: runs over the n entries of the opposite side, reporting trades and a closing result;
//   every entry is read and written back compacted, at most one trade per entry.
// One transaction in process at a time; the next is taken the cycle after the final
//   result loads, and results leave through one register (receiver stalls hold processing).
// Reset clears the counts and control; book memory holds no reset value.
// ----------------------------------------------------------------------------
module order_book_matcher #(
	parameter int SIDE_DEPTH = obm_pkg::SIDE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic        side,
	input  logic [15:0] instrument,
	input  logic [31:0] order_id,
	input  logic [31:0] price,
	input  logic [31:0] quantity,
	input  logic [31:0] order_time,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [31:0] buyer_id,
	output logic [31:0] seller_id,
	output logic [15:0] trade_instrument,
	output logic [31:0] trade_quantity,
	output logic [31:0] trade_price,
	output logic [31:0] remaining,
	output logic        last
);

	localparam int AW = $clog2(2 * SIDE_DEPTH);
	localparam int CW = $clog2(SIDE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_REFUSE, ST_ADD_RD, ST_ADD_PROC, ST_ADD_FIRST, ST_MT_RD, ST_MT_PROC
	} state_t;

	state_t state_q;

	// Latched transaction
	logic        func_q, side_q;
	logic [15:0] instr_q;
	logic [31:0] id_q, price_q, qty_q, time_q;
	logic [CW-1:0] i_q, w_q, buy_cnt_q, sell_cnt_q;

	// Output register
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [31:0] buyer_q, seller_q, tqty_q, tprice_q, rem_q;
	logic [15:0] tinstr_q;
	logic        last_q;

	logic            we, rd_en, out_load;
	logic [AW-1:0]   wr_addr, rd_addr, base;
	obm_pkg::entry_t wr_data, rd_data, new_e;
	logic            hi, slot_free, gb, crosses, hit, keep;
	logic [CW-1:0]   cnt_sel, in_cnt;
	logic [31:0]     amt, rest_qty;

	obm_book_ram #(.SIDE_DEPTH(SIDE_DEPTH)) u_ram (
		.clk(clk), .we(we), .wr_addr(wr_addr), .wr_data(wr_data),
		.rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
	);

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_cnt    = (side == obm_pkg::SIDE_BUY) ? buy_cnt_q : sell_cnt_q;

	always_comb begin
		// Adds work on their own side, matches on the opposite one; sells in the high half
		hi      = (func_q == obm_pkg::FUNC_MATCH) ? side_q : !side_q;
		cnt_sel = hi ? sell_cnt_q : buy_cnt_q;
		base    = hi ? AW'(SIDE_DEPTH) : '0;
		new_e   = '{price: price_q, qty: qty_q, otime: time_q, ident: id_q, instr: instr_q};

		gb = (price_q != rd_data.price)
			? ((side_q == obm_pkg::SIDE_BUY) ? (price_q > rd_data.price)
			                                  : (price_q < rd_data.price))
			: (time_q < rd_data.otime);
		crosses = (side_q == obm_pkg::SIDE_BUY) ? (price_q >= rd_data.price)
		                                         : (price_q <= rd_data.price);
		hit  = (qty_q != '0) && (rd_data.instr == instr_q) && crosses && (rd_data.qty != '0);
		amt  = (qty_q < rd_data.qty) ? qty_q : rd_data.qty;
		rest_qty = rd_data.qty - amt;
		keep = !hit || (rest_qty != '0);

		we       = 1'b0;
		wr_addr  = '0;
		wr_data  = rd_data;
		rd_en    = 1'b0;
		rd_addr  = '0;
		out_load = 1'b0;
		case (state_q)
			ST_REFUSE: begin
				out_load = slot_free;
			end
			ST_ADD_RD: begin
				rd_en   = 1'b1;
				rd_addr = base + AW'(i_q - 1'b1);
			end
			ST_ADD_PROC: begin
				we       = slot_free || gb;
				wr_addr  = base + AW'(i_q);
				wr_data  = gb ? rd_data : new_e;
				out_load = slot_free && !gb;
			end
			ST_ADD_FIRST: begin
				we       = slot_free;
				wr_addr  = base;
				wr_data  = new_e;
				out_load = slot_free;
			end
			ST_MT_RD: begin
				rd_en    = (i_q != cnt_sel);
				rd_addr  = base + AW'(i_q);
				out_load = slot_free && (i_q == cnt_sel);
			end
			ST_MT_PROC: begin
				// Compact: drop filled entries, pull the rest forward
				we       = slot_free && keep;
				wr_addr  = base + AW'(w_q);
				wr_data  = rd_data;
				out_load = slot_free && hit;
				if (hit) begin
					wr_data.qty = rest_qty;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			buy_cnt_q   <= '0;
			sell_cnt_q  <= '0;
			i_q         <= '0;
			w_q         <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						func_q  <= func;
						side_q  <= side;
						instr_q <= instrument;
						id_q    <= order_id;
						price_q <= price;
						qty_q   <= quantity;
						time_q  <= order_time;
						i_q     <= (func == obm_pkg::FUNC_MATCH) ? '0 : in_cnt;
						w_q     <= '0;
						if (func == obm_pkg::FUNC_MATCH) begin
							state_q <= ST_MT_RD;
						end else if (in_cnt >= CW'(SIDE_DEPTH)) begin
							state_q <= ST_REFUSE;
						end else if (in_cnt == '0) begin
							state_q <= ST_ADD_FIRST;
						end else begin
							state_q <= ST_ADD_RD;
						end
					end
				end
				ST_REFUSE: begin
					if (slot_free) begin
						kind_q <= obm_pkg::KIND_FULL;
						buyer_q <= '0; seller_q <= '0; tinstr_q <= '0;
						tqty_q <= '0; tprice_q <= '0; rem_q <= '0; last_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_ADD_RD: begin
					state_q <= ST_ADD_PROC;
				end
				ST_ADD_PROC: begin
					if (gb) begin
						// Shift the entry back one slot and keep scanning
						i_q <= i_q - 1'b1;
						state_q <= (i_q == CW'(1)) ? ST_ADD_FIRST : ST_ADD_RD;
					end else if (slot_free) begin
						kind_q <= obm_pkg::KIND_ADDED;
						buyer_q <= '0; seller_q <= '0; tinstr_q <= '0;
						tqty_q <= '0; tprice_q <= '0; rem_q <= '0; last_q <= 1'b1;
						if (side_q == obm_pkg::SIDE_BUY) buy_cnt_q <= buy_cnt_q + 1'b1;
						else sell_cnt_q <= sell_cnt_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_ADD_FIRST: begin
					if (slot_free) begin
						kind_q <= obm_pkg::KIND_ADDED;
						buyer_q <= '0; seller_q <= '0; tinstr_q <= '0;
						tqty_q <= '0; tprice_q <= '0; rem_q <= '0; last_q <= 1'b1;
						if (side_q == obm_pkg::SIDE_BUY) buy_cnt_q <= buy_cnt_q + 1'b1;
						else sell_cnt_q <= sell_cnt_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_MT_RD: begin
					if (i_q == cnt_sel) begin
						if (slot_free) begin
							kind_q <= obm_pkg::KIND_DONE;
							buyer_q <= '0; seller_q <= '0; tinstr_q <= '0;
							tqty_q <= '0; tprice_q <= '0; rem_q <= qty_q; last_q <= 1'b1;
							if (hi) sell_cnt_q <= w_q;
							else buy_cnt_q <= w_q;
							state_q <= ST_IDLE;
						end
					end else begin
						state_q <= ST_MT_PROC;
					end
				end
				ST_MT_PROC: begin
					if (slot_free) begin
						if (hit) begin
							kind_q   <= obm_pkg::KIND_TRADE;
							buyer_q  <= (side_q == obm_pkg::SIDE_BUY) ? id_q : rd_data.ident;
							seller_q <= (side_q == obm_pkg::SIDE_BUY) ? rd_data.ident : id_q;
							tinstr_q <= instr_q;
							tqty_q   <= amt;
							tprice_q <= (side_q == obm_pkg::SIDE_BUY) ? price_q : rd_data.price;
							rem_q    <= '0;
							last_q   <= 1'b0;
							qty_q    <= qty_q - amt;
						end
						if (keep) w_q <= w_q + 1'b1;
						i_q <= i_q + 1'b1;
						state_q <= ST_MT_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign kind             = kind_q;
	assign buyer_id         = buyer_q;
	assign seller_id        = seller_q;
	assign trade_instrument = tinstr_q;
	assign trade_quantity   = tqty_q;
	assign trade_price      = tprice_q;
	assign remaining        = rem_q;
	assign last             = last_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		buy_cnt_q <= CW'(SIDE_DEPTH) && sell_cnt_q <= CW'(SIDE_DEPTH))
		else $error("side count above depth");
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !we)
		else $error("book write while idle");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q != ST_IDLE)
		else $error("accepted transaction not processed");
	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MT_PROC |-> w_q <= i_q)
		else $error("compaction write ahead of read");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the order book matcher: a directed table of adds and matches,
// a fill of the sell side to a refused add, then random order flow, checked against a book model.
// ----------------------------------------------------------------------------
module tb;

	localparam int DEPTH = obm_pkg::SIDE_DEPTH_DEF;

	typedef struct packed {
		logic        fn;
		logic        sd;
		logic [15:0] instr;
		logic [31:0] id;
		logic [31:0] px;
		logic [31:0] qty;
		logic [31:0] otime;
	} order_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] buyer;
		logic [31:0] seller;
		logic [15:0] instr;
		logic [31:0] qty;
		logic [31:0] px;
		logic [31:0] rem;
		logic        last;
	} report_t;

	typedef struct packed {
		logic        check_kind;
		logic [1:0]  kind;
		order_t      ord;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        func = 1'b0;
	logic        side = 1'b0;
	logic [15:0] instrument = '0;
	logic [31:0] order_id = '0;
	logic [31:0] price = '0;
	logic [31:0] quantity = '0;
	logic [31:0] order_time = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [31:0] buyer_id;
	logic [31:0] seller_id;
	logic [15:0] trade_instrument;
	logic [31:0] trade_quantity;
	logic [31:0] trade_price;
	logic [31:0] remaining;
	logic        last;

	order_book_matcher #(.SIDE_DEPTH(DEPTH)) dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#200_000_000;
		$display("order_book_matcher: mismatch");
		$finish;
	end

	// Model book: index 0 is the head of each side.
	obm_pkg::entry_t bids[$];
	obm_pkg::entry_t asks[$];
	report_t pending_reports[$];
	row_t    directed[$];
	int      fail_count = 0;
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;

	// Append an expected report at the tail.
	function automatic void queue_report(report_t r);
		pending_reports.insert(pending_reports.size(), r);
	endfunction

	function automatic void add_row(row_t r);
		directed.insert(directed.size(), r);
	endfunction

	function automatic bit ahead_of(bit buy, obm_pkg::entry_t a, obm_pkg::entry_t b);
		if (a.price != b.price)
			return buy ? (a.price > b.price) : (a.price < b.price);
		return a.otime < b.otime;
	endfunction

	// Work out the reports for one order and update the model book.
	task automatic book_order(order_t o);
		obm_pkg::entry_t e;
		report_t r;
		logic [31:0] left;
		logic [31:0] amt;
		int pos;
		int i;
		e = '{price: o.px, qty: o.qty, otime: o.otime, ident: o.id, instr: o.instr};
		r = '0;
		r.last = 1'b1;
		if (o.fn == obm_pkg::FUNC_ADD) begin
			if (o.sd == obm_pkg::SIDE_BUY) begin
				if (bids.size() >= DEPTH) r.kind = obm_pkg::KIND_FULL;
				else begin
					pos = 0;
					while (pos < bids.size() && !ahead_of(1'b1, e, bids[pos])) pos++;
					bids.insert(pos, e);
					r.kind = obm_pkg::KIND_ADDED;
				end
			end else begin
				if (asks.size() >= DEPTH) r.kind = obm_pkg::KIND_FULL;
				else begin
					pos = 0;
					while (pos < asks.size() && !ahead_of(1'b0, e, asks[pos])) pos++;
					asks.insert(pos, e);
					r.kind = obm_pkg::KIND_ADDED;
				end
			end
			queue_report(r);
			return;
		end
		left = o.qty;
		i = 0;
		if (o.sd == obm_pkg::SIDE_BUY) begin
			while (i < asks.size() && left != 0) begin
				if (asks[i].instr == o.instr && o.px >= asks[i].price && asks[i].qty != 0) begin
					amt = (left < asks[i].qty) ? left : asks[i].qty;
					queue_report('{obm_pkg::KIND_TRADE, o.id, asks[i].ident, o.instr,
						amt, o.px, 32'd0, 1'b0});
					left -= amt;
					asks[i].qty -= amt;
					if (asks[i].qty == 0) begin
						asks.delete(i);
						continue;
					end
				end
				i++;
			end
		end else begin
			while (i < bids.size() && left != 0) begin
				if (bids[i].instr == o.instr && o.px <= bids[i].price && bids[i].qty != 0) begin
					amt = (left < bids[i].qty) ? left : bids[i].qty;
					queue_report('{obm_pkg::KIND_TRADE, bids[i].ident, o.id, o.instr,
						amt, bids[i].price, 32'd0, 1'b0});
					left -= amt;
					bids[i].qty -= amt;
					if (bids[i].qty == 0) begin
						bids.delete(i);
						continue;
					end
				end
				i++;
			end
		end
		r.kind = obm_pkg::KIND_DONE;
		r.rem = left;
		queue_report(r);
	endtask

	// Drive one transaction at the falling edge and hold it until accepted.
	task automatic send_order(order_t o);
		while (($urandom_range(99) < send_idle_pct)) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		{func, side, instrument, order_id, price, quantity, order_time} = o;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		book_order(o);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Sample reports at the rising edge and compare with the oldest expectation.
	always @(posedge clk) begin
		report_t got;
		report_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{kind, buyer_id, seller_id, trade_instrument, trade_quantity,
				trade_price, remaining, last};
			if (pending_reports.size() == 0) begin
				$display("%0t unexpected report %h", $time, got);
				fail_count++;
			end else begin
				want = pending_reports.pop_front();
				if (got !== want) begin
					$display("%0t expected %h actual %h", $time, want, got);
					fail_count++;
				end
			end
		end
	end

	// Receiver stall pattern, redrawn at each falling edge.
	always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

	function automatic order_t rand_order(bit fn, int n_instr, int px_lo, int px_hi);
		order_t o;
		o.fn = fn;
		o.sd = 1'($urandom_range(1));
		o.instr = (n_instr == 0) ? 16'($urandom) : 16'($urandom_range(n_instr - 1));
		o.id = $urandom;
		o.px = (px_hi == 0) ? $urandom : $urandom_range(px_hi, px_lo);
		o.qty = ($urandom_range(9) == 0) ? $urandom : $urandom_range(40);
		o.otime = ($urandom_range(9) == 0) ? $urandom : $urandom_range(30);
		return o;
	endfunction

	initial begin
		order_t o;
		int n;
		int k;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed rows: empty-book match, extreme fields, priority and partial fills.
		add_row('{1, obm_pkg::KIND_DONE, '{obm_pkg::FUNC_MATCH, obm_pkg::SIDE_BUY, 16'h0,
			32'h1, '1, 32'd5, 0}});
		add_row('{1, obm_pkg::KIND_ADDED, '{obm_pkg::FUNC_ADD, obm_pkg::SIDE_SELL, 16'hFFFF,
			'1, '1, '1, '1}});
		add_row('{1, obm_pkg::KIND_ADDED, '{obm_pkg::FUNC_ADD, obm_pkg::SIDE_SELL, 16'hFFFF,
			32'd2, 32'd100, 32'd0, 32'd0}});
		add_row('{1, obm_pkg::KIND_ADDED, '{obm_pkg::FUNC_ADD, obm_pkg::SIDE_SELL, 16'hFFFF,
			32'd3, 32'd100, 32'd10, 32'd5}});
		add_row('{1, obm_pkg::KIND_ADDED, '{obm_pkg::FUNC_ADD, obm_pkg::SIDE_SELL, 16'hFFFF,
			32'd4, 32'd100, 32'd7, 32'd2}});
		add_row('{0, obm_pkg::KIND_TRADE, '{obm_pkg::FUNC_MATCH, obm_pkg::SIDE_BUY, 16'hFFFF,
			32'd9, 32'd100, 32'd12, 32'd0}});
		add_row('{0, obm_pkg::KIND_TRADE, '{obm_pkg::FUNC_MATCH, obm_pkg::SIDE_BUY, 16'hFFFF,
			32'd10, '1, '1, 32'd0}});
		add_row('{1, obm_pkg::KIND_ADDED, '{obm_pkg::FUNC_ADD, obm_pkg::SIDE_BUY, 16'h0,
			32'd20, 32'd0, 32'd0, '1}});
		add_row('{1, obm_pkg::KIND_ADDED, '{obm_pkg::FUNC_ADD, obm_pkg::SIDE_BUY, 16'h7,
			32'd21, 32'd50, 32'd9, 32'd1}});
		add_row('{1, obm_pkg::KIND_ADDED, '{obm_pkg::FUNC_ADD, obm_pkg::SIDE_BUY, 16'h7,
			32'd22, 32'd60, 32'd4, 32'd3}});
		add_row('{0, obm_pkg::KIND_TRADE, '{obm_pkg::FUNC_MATCH, obm_pkg::SIDE_SELL, 16'h7,
			32'd30, 32'd0, 32'd20, 32'd0}});
		add_row('{0, obm_pkg::KIND_TRADE, '{obm_pkg::FUNC_MATCH, obm_pkg::SIDE_SELL, 16'h0,
			32'd31, 32'd0, 32'd5, 32'd0}});
		add_row('{1, obm_pkg::KIND_DONE, '{obm_pkg::FUNC_MATCH, obm_pkg::SIDE_SELL, 16'h7,
			32'd32, '1, 32'd0, 32'd0}});
		foreach (directed[i]) begin
			send_order(directed[i].ord);
			if (directed[i].check_kind && pending_reports[$].kind != directed[i].kind) begin
				$display("%0t row %0d expected kind %0d actual %0d", $time, i,
					directed[i].kind, pending_reports[$].kind);
				fail_count++;
			end
		end
		// Fill the sell side to the brim, then one refused add.
		while (asks.size() < DEPTH) begin
			o = rand_order(obm_pkg::FUNC_ADD, 2, 200, 260);
			o.sd = obm_pkg::SIDE_SELL;
			send_order(o);
		end
		o = rand_order(obm_pkg::FUNC_ADD, 2, 200, 260);
		o.sd = obm_pkg::SIDE_SELL;
		send_order(o);
		if (pending_reports[$].kind != obm_pkg::KIND_FULL) begin
			$display("%0t expected kind %0d actual %0d", $time, obm_pkg::KIND_FULL,
				pending_reports[$].kind);
			fail_count++;
		end

		// Random flow in idle phases: none, sender, receiver, both.
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 7 : 49) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 7 : 49) : 0;
			n = 34;
			for (k = 0; k < n; k++) begin
				if ($urandom_range(9) == 0) o = rand_order(1'($urandom_range(1)), 0, 0, 0);
				else begin
					o = rand_order($urandom_range(99) < 45, 3, 90, 130);
					if (o.fn == obm_pkg::FUNC_MATCH && $urandom_range(3) == 0)
						o.qty = $urandom_range(200);
				end
				send_order(o);
			end
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("order_book_matcher: match");
		else
			$display("order_book_matcher: mismatch");
		$finish;
	end

endmodule

@@ filelist.f @@
design/obm_pkg.sv
design/obm_book_ram.sv
design/order_book_matcher.sv
test/tb.sv
